// ----- src/assert_macros.svh -----
// Assertion macros used by the allocator sequencer (bba_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/bba_pkg.sv -----
// Types and constants of the buddy block allocator.
package bba_pkg;

    localparam int LG_BLOCKS_DEF = 10;
    localparam int N_W           = 11;
    localparam int IDX_W         = 10;
    localparam int STAT_W        = 2;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_SPACE   = 2'd1,
        STAT_BAD_SIZE   = 2'd2,
        STAT_MISALIGNED = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_POPW, S_SRCH, S_SPOPW, S_SPUSH2, S_SNEXT, S_CHK,
        S_CSTART, S_SI, S_SKEY, S_SJ, S_SCMP, S_MI, S_MA, S_MB, S_MR1,
        S_MR1W, S_MR2W, S_FIN, S_DONE
    } state_t;

endpackage

// ----- src/bba_store.sv -----
// Free-list store: one write port, one read port, registered read data.
module bba_store #(
    parameter int AW = 11,
    parameter int VW = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [VW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [VW-1:0] rdata
);

    logic [VW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/bba_ctrl.sv -----
// Allocator sequencer: level counts, pop/push, split and sort-merge coalescing.
`include "assert_macros.svh"
module bba_ctrl import bba_pkg::*; #(
    parameter int LG = LG_BLOCKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmd_t              in_cmd,
    input  logic [N_W-1:0]    in_n,
    input  logic [IDX_W-1:0]  in_idx,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [IDX_W-1:0]  res_idx,
    output status_t           res_status
);

    localparam int AW = LG + 1;
    localparam int VW = LG;
    localparam int CW = LG + 1;
    localparam int LW = $clog2(LG + 2);

    function automatic logic [AW-1:0] base_of(input logic [LW-1:0] l);
        logic [31:0] b;
        b = (32'd2 << LG) - (32'd2 << (LG - 32'(l)));
        return b[AW-1:0];
    endfunction

    function automatic logic [CW-1:0] cap_of(input logic [LW-1:0] l);
        logic [31:0] c;
        c = 32'd1 << (LG - 32'(l));
        return c[CW-1:0];
    endfunction

    state_t          state_reg, state_next;
    logic [LW-1:0]   lv_reg, lv_next;
    logic [LW-1:0]   k_reg, k_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [VW-1:0]   key_reg, key_next;
    logic [VW-1:0]   a_reg, a_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    status_t         res_st_reg, res_st_next;
    logic [CW-1:0]   cnt_reg [0:LG];

    logic            cnt_we;
    logic [LW-1:0]   cnt_wl;
    logic [CW-1:0]   cnt_wd;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [VW-1:0]   mem_wdata, mem_rdata;

    logic            do_pop;
    logic [LW-1:0]   pop_l;
    logic [LW-1:0]   lv_in;
    logic [LW-1:0]   s_l;
    logic [31:0]     nm1, idx32, hi32;
    logic            bad_size, misaligned, aligned, pair;

    bba_store #(.AW(AW), .VW(VW)) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        nm1   = 32'(in_n) - 32'd1;
        lv_in = '0;
        for (int b = 0; b < N_W; b++) begin
            if (nm1[b]) begin
                lv_in = LW'(b + 1);
            end
        end
        idx32      = 32'(in_idx);
        bad_size   = (in_n == '0) || (32'(in_n) > (32'd1 << LG));
        misaligned = (idx32 >= (32'd1 << LG)) ||
                     ((idx32 & ((32'd1 << lv_in) - 32'd1)) != 32'd0);
        s_l        = k_reg - LW'(1);
        hi32       = 32'(a_reg) + (32'd1 << s_l);
        aligned    = (32'(a_reg) & ((32'd1 << k_reg) - 32'd1)) == 32'd0;
        pair       = 32'(mem_rdata) == hi32;
    end

    always_comb begin
        state_next   = state_reg;
        lv_next      = lv_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        key_next     = key_reg;
        a_next       = a_reg;
        res_idx_next = res_idx_reg;
        res_st_next  = res_st_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        cnt_we       = 1'b0;
        cnt_wl       = '0;
        cnt_wd       = '0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        do_pop       = 1'b0;
        pop_l        = '0;

        case (state_reg)
            S_INIT: begin
                mem_we     = 1'b1;
                mem_waddr  = base_of(LW'(LG));
                state_next = S_IDLE;
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    lv_next      = lv_in;
                    res_idx_next = '0;
                    res_st_next  = STAT_OK;
                    if (bad_size) begin
                        res_st_next = STAT_BAD_SIZE;
                        state_next  = S_DONE;
                    end else if (in_cmd == CMD_FREE) begin
                        if (misaligned) begin
                            res_st_next = STAT_MISALIGNED;
                        end else if (cnt_reg[lv_in] >= cap_of(lv_in)) begin
                            res_st_next = STAT_NO_SPACE;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = base_of(lv_in) + AW'(cnt_reg[lv_in]);
                            mem_wdata = idx32[VW-1:0];
                            cnt_we    = 1'b1;
                            cnt_wl    = lv_in;
                            cnt_wd    = cnt_reg[lv_in] + CW'(1);
                        end
                        state_next = S_DONE;
                    end else if (cnt_reg[lv_in] != '0) begin
                        do_pop     = 1'b1;
                        pop_l      = lv_in;
                        state_next = S_POPW;
                    end else begin
                        k_next     = lv_in + LW'(1);
                        state_next = S_SRCH;
                    end
                end
            end
            S_POPW: begin
                res_idx_next = IDX_W'(32'(mem_rdata));
                res_st_next  = STAT_OK;
                state_next   = S_DONE;
            end
            S_SRCH: begin
                if (k_reg > LW'(LG)) begin
                    k_next     = LW'(1);
                    state_next = S_CSTART;
                end else if (cnt_reg[k_reg] != '0) begin
                    do_pop     = 1'b1;
                    pop_l      = k_reg;
                    state_next = S_SPOPW;
                end else begin
                    k_next = k_reg + LW'(1);
                end
            end
            S_SPOPW: begin
                a_next = mem_rdata;
                if (cnt_reg[s_l] < cap_of(s_l)) begin
                    mem_we    = 1'b1;
                    mem_waddr = base_of(s_l) + AW'(cnt_reg[s_l]);
                    mem_wdata = mem_rdata;
                    cnt_we    = 1'b1;
                    cnt_wl    = s_l;
                    cnt_wd    = cnt_reg[s_l] + CW'(1);
                end
                state_next = S_SPUSH2;
            end
            S_SPUSH2: begin
                if (cnt_reg[s_l] < cap_of(s_l)) begin
                    mem_we    = 1'b1;
                    mem_waddr = base_of(s_l) + AW'(cnt_reg[s_l]);
                    mem_wdata = hi32[VW-1:0];
                    cnt_we    = 1'b1;
                    cnt_wl    = s_l;
                    cnt_wd    = cnt_reg[s_l] + CW'(1);
                end
                k_next     = s_l;
                state_next = S_SNEXT;
            end
            S_SNEXT: begin
                if (k_reg == lv_reg || cnt_reg[k_reg] == '0) begin
                    state_next = S_CHK;
                end else begin
                    do_pop     = 1'b1;
                    pop_l      = k_reg;
                    state_next = S_SPOPW;
                end
            end
            S_CHK: begin
                if (cnt_reg[lv_reg] != '0) begin
                    do_pop     = 1'b1;
                    pop_l      = lv_reg;
                    state_next = S_POPW;
                end else begin
                    k_next     = LW'(1);
                    state_next = S_CSTART;
                end
            end
            S_CSTART: begin
                if (k_reg > lv_reg) begin
                    state_next = S_FIN;
                end else if (cnt_reg[s_l] < CW'(2)) begin
                    k_next = k_reg + LW'(1);
                end else begin
                    n_next     = cnt_reg[s_l];
                    i_next     = CW'(1);
                    state_next = S_SI;
                end
            end
            S_SI: begin
                if (i_reg >= n_reg) begin
                    i_next     = '0;
                    state_next = S_MI;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = base_of(s_l) + AW'(i_reg);
                    state_next = S_SKEY;
                end
            end
            S_SKEY: begin
                key_next   = mem_rdata;
                j_next     = i_reg;
                state_next = S_SJ;
            end
            S_SJ: begin
                if (j_reg == '0) begin
                    mem_we     = 1'b1;
                    mem_waddr  = base_of(s_l);
                    mem_wdata  = key_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SI;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = base_of(s_l) + AW'(j_reg - CW'(1));
                    state_next = S_SCMP;
                end
            end
            S_SCMP: begin
                mem_we    = 1'b1;
                mem_waddr = base_of(s_l) + AW'(j_reg);
                if (mem_rdata > key_reg) begin
                    mem_wdata  = mem_rdata;
                    j_next     = j_reg - CW'(1);
                    state_next = S_SJ;
                end else begin
                    mem_wdata  = key_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SI;
                end
            end
            S_MI: begin
                if (n_reg < CW'(2) || (i_reg + CW'(1)) >= n_reg) begin
                    cnt_we     = 1'b1;
                    cnt_wl     = s_l;
                    cnt_wd     = n_reg;
                    k_next     = k_reg + LW'(1);
                    state_next = S_CSTART;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = base_of(s_l) + AW'(i_reg);
                    state_next = S_MA;
                end
            end
            S_MA: begin
                a_next     = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = base_of(s_l) + AW'(i_reg + CW'(1));
                state_next = S_MB;
            end
            S_MB: begin
                if (aligned && pair && cnt_reg[k_reg] < cap_of(k_reg)) begin
                    mem_we     = 1'b1;
                    mem_waddr  = base_of(k_reg) + AW'(cnt_reg[k_reg]);
                    mem_wdata  = a_reg;
                    cnt_we     = 1'b1;
                    cnt_wl     = k_reg;
                    cnt_wd     = cnt_reg[k_reg] + CW'(1);
                    state_next = S_MR1;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_MI;
                end
            end
            S_MR1: begin
                mem_re     = 1'b1;
                mem_raddr  = base_of(s_l) + AW'(n_reg - CW'(2));
                state_next = S_MR1W;
            end
            S_MR1W: begin
                mem_we     = 1'b1;
                mem_waddr  = base_of(s_l) + AW'(i_reg);
                mem_wdata  = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = base_of(s_l) + AW'(n_reg - CW'(1));
                state_next = S_MR2W;
            end
            S_MR2W: begin
                mem_we     = 1'b1;
                mem_waddr  = base_of(s_l) + AW'(i_reg + CW'(1));
                mem_wdata  = mem_rdata;
                n_next     = n_reg - CW'(2);
                state_next = S_MI;
            end
            S_FIN: begin
                if (cnt_reg[lv_reg] != '0) begin
                    do_pop     = 1'b1;
                    pop_l      = lv_reg;
                    state_next = S_POPW;
                end else begin
                    res_idx_next = '0;
                    res_st_next  = STAT_NO_SPACE;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (do_pop) begin
            mem_re    = 1'b1;
            mem_raddr = base_of(pop_l) + AW'(cnt_reg[pop_l] - CW'(1));
            cnt_we    = 1'b1;
            cnt_wl    = pop_l;
            cnt_wd    = cnt_reg[pop_l] - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            for (int l = 0; l <= LG; l++) begin
                cnt_reg[l] <= (l == LG) ? CW'(1) : '0;
            end
        end else begin
            state_reg <= state_next;
            if (cnt_we) begin
                cnt_reg[cnt_wl] <= cnt_wd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lv_reg      <= lv_next;
        k_reg       <= k_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        n_reg       <= n_next;
        key_reg     <= key_next;
        a_reg       <= a_next;
        res_idx_reg <= res_idx_next;
        res_st_reg  <= res_st_next;
    end

    assign res_idx    = res_idx_reg;
    assign res_status = res_st_reg;

    `BBA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != S_IDLE)
    `BBA_ASSERT_NEXT(a_done_holds, state_reg == S_DONE && !res_ready, state_reg == S_DONE)
    `BBA_ASSERT(a_top_level_cap, cnt_reg[LG] <= CW'(1))
    `BBA_ASSERT(a_level0_cap, cnt_reg[0] <= cap_of('0))
    `BBA_ASSERT(a_no_write_in_done, state_reg != S_DONE || !mem_we)

endmodule

// ----- src/buddy_block_allocator_core.sv -----
// Buddy block allocator: stream ports and result register.
//
// Input stream s_*: s_tuser = cmd (0 allocate, 1 free); s_tdata holds n_blocks
// and block_index. Each item yields exactly one result on m_*: m_tdata holds
// the granted block index (zero unless an allocate succeeds), m_tuser the
// status (ok, no space, bad size, misaligned free).
// One item is in work at a time. A free goes from accept straight to the result
// state; a pop first waits in S_POPW for the read of the free-list store. A split
// searches the levels upward one by one and halves each level through S_SPOPW,
// S_SPUSH2 and S_SNEXT. When no larger block is free, coalescing insertion-sorts
// each lower level in the store and then merges aligned buddy pairs one level up.
// The sequencing is set by the single read and single write port of the
// free-list store.
// Reset clears the level counts, marks the whole heap free at the top level
// and writes that entry in S_INIT before s_tready rises.
// A stalled m_tready holds the result; the next item is taken once the
// result register has room.
module buddy_block_allocator_core import bba_pkg::*; #(
    parameter int LG_BLOCKS = LG_BLOCKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [10:0] n_blocks, [20:11] block_index
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] block_index_out
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic             res_valid, res_ready;
    logic [IDX_W-1:0] res_idx;
    status_t          res_status;
    logic             m_valid_reg;
    logic [IDX_W-1:0] m_idx_reg;
    status_t          m_st_reg;

    bba_ctrl #(.LG(LG_BLOCKS)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (cmd_t'(s_tuser[0])),
        .in_n       (s_tdata[10:0]),
        .in_idx     (s_tdata[20:11]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_idx    (res_idx),
        .res_status (res_status)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_idx_reg <= res_idx;
            m_st_reg  <= res_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_idx_reg};
    assign m_tuser  = m_st_reg;

endmodule

// ----- dv/buddy_block_allocator_core_tb.sv -----
// Testbench for the buddy block allocator core: directed and random alloc/free items checked against a predictor.
module buddy_block_allocator_core_tb;
    import bba_pkg::*;

    localparam int LG     = LG_BLOCKS_DEF;
    localparam int HEAP   = 1 << LG;
    localparam int DEPTH  = 2 << LG;
    localparam int N_RAND = 1650;

    typedef struct {
        cmd_t             cmd;
        logic [N_W-1:0]   n;
        logic [IDX_W-1:0] idx;
    } alloc_req_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        status_t          stat;
    } alloc_resp_t;

    typedef struct {
        int idx;
        int n;
    } region_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    buddy_block_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    alloc_req_t  req_q[$];
    alloc_resp_t resp_q[$];
    region_t     live[$];
    region_t     freed[$];
    int          errors = 0;
    int          n_resp = 0;
    int          n_ok = 0, n_nospace = 0, n_bad = 0, n_misal = 0;

    // predictor state
    int fl_store[DEPTH];
    int fl_cnt[LG+1];

    function automatic int lvl_base(int l);
        return DEPTH - (2 << (LG - l));
    endfunction

    function automatic int lvl_cap(int l);
        return 1 << (LG - l);
    endfunction

    function automatic bit fl_push(int l, int v);
        if (fl_cnt[l] >= lvl_cap(l)) return 1'b0;
        fl_store[lvl_base(l) + fl_cnt[l]] = v;
        fl_cnt[l]++;
        return 1'b1;
    endfunction

    function automatic int fl_pop(int l);
        fl_cnt[l]--;
        return fl_store[lvl_base(l) + fl_cnt[l]];
    endfunction

    function automatic void split_from(int lv);
        int h;
        int v;
        bit ok;
        h = lv + 1;
        while (h <= LG && fl_cnt[h] == 0) h++;
        if (h > LG) return;
        for (int k = h; k > lv; k--) begin
            if (fl_cnt[k] == 0) return;
            v = fl_pop(k);
            ok = fl_push(k - 1, v);
            ok = fl_push(k - 1, v + (1 << (k - 1)));
        end
    endfunction

    function automatic void coalesce_into(int t);
        int s, b, n, i, j, key, a;
        bit merged;
        s = t - 1;
        b = lvl_base(s);
        n = fl_cnt[s];
        if (n < 2) return;
        for (i = 1; i < n; i++) begin
            key = fl_store[b + i];
            j = i;
            while (j > 0 && fl_store[b + j - 1] > key) begin
                fl_store[b + j] = fl_store[b + j - 1];
                j--;
            end
            fl_store[b + j] = key;
        end
        i = 0;
        while (n >= 2 && i < n - 1) begin
            a = fl_store[b + i];
            merged = 1'b0;
            if ((a & ((1 << t) - 1)) == 0 && fl_store[b + i + 1] == a + (1 << s))
                merged = fl_push(t, a);
            if (merged) begin
                fl_store[b + i] = fl_store[b + n - 2];
                fl_store[b + i + 1] = fl_store[b + n - 1];
                n -= 2;
            end else begin
                i++;
            end
        end
        fl_cnt[s] = n;
    endfunction

    function automatic alloc_resp_t predict_alloc(alloc_req_t r);
        alloc_resp_t o;
        int lv;
        int n;
        n = r.n;
        o.idx = '0;
        o.stat = STAT_OK;
        if (n == 0 || n > HEAP) begin
            o.stat = STAT_BAD_SIZE;
            return o;
        end
        lv = 0;
        while ((1 << lv) < n) lv++;
        if (r.cmd == CMD_ALLOC) begin
            if (fl_cnt[lv] == 0) split_from(lv);
            if (fl_cnt[lv] == 0)
                for (int t = 1; t <= lv; t++) coalesce_into(t);
            if (fl_cnt[lv] == 0) o.stat = STAT_NO_SPACE;
            else o.idx = IDX_W'(fl_pop(lv));
        end else begin
            if (int'(r.idx) >= HEAP || (r.idx & ((1 << lv) - 1)) != 0)
                o.stat = STAT_MISALIGNED;
            else if (!fl_push(lv, r.idx))
                o.stat = STAT_NO_SPACE;
        end
        return o;
    endfunction

    task automatic issue(cmd_t c, int n, int idx);
        alloc_req_t  r;
        alloc_resp_t o;
        region_t     g;
        r.cmd = c;
        r.n = N_W'(n);
        r.idx = IDX_W'(idx);
        o = predict_alloc(r);
        if (c == CMD_ALLOC && o.stat == STAT_OK) begin
            g.idx = o.idx;
            g.n = n;
            live.push_back(g);
        end
        req_q.push_back(r);
        resp_q.push_back(o);
    endtask

    task automatic free_live(int k);
        region_t g;
        g = live[k];
        live.delete(k);
        issue(CMD_FREE, g.n, g.idx);
        freed.push_back(g);
        if (freed.size() > 8) void'(freed.pop_front());
    endtask

    function automatic int rand_size();
        int lv;
        lv = ($urandom_range(0, 19) == 0) ? $urandom_range(7, LG) : $urandom_range(0, 6);
        if (lv == 0) return 1;
        return $urandom_range((1 << (lv - 1)) + 1, 1 << lv);
    endfunction

    // driver
    bit s_took = 1'b0, m_took = 1'b0;
    int s_gap = 0, m_gap = 0;
    bit calm = 1'b0;
    int drv_cnt = 0;

    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
        m_took <= m_tvalid && m_tready;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    always @(negedge aclk) begin
        logic v;
        alloc_req_t r;
        if (aresetn) begin
            v = s_tvalid;
            if (v && s_took) v = 1'b0;
            if (!v) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (req_q.size() > 0) begin
                    r = req_q.pop_front();
                    s_tdata <= {3'b0, r.idx, r.n};
                    s_tuser <= r.cmd;
                    v = 1'b1;
                    drv_cnt++;
                    if (drv_cnt % 150 == 0) calm = ~calm;
                    s_gap = draw_gap();
                end
            end
            s_tvalid <= v;
            if (m_took) m_gap = draw_gap();
            else if (m_gap > 0) m_gap--;
            m_tready <= (m_gap == 0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        alloc_resp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_resp++;
            if (resp_q.size() == 0) begin
                $display("%0t: unexpected result idx=%0d status=%0d", $time,
                         m_tdata[9:0], m_tuser);
                errors++;
            end else begin
                e = resp_q.pop_front();
                if (m_tdata[9:0] !== e.idx || m_tdata[15:10] !== '0) begin
                    $display("%0t: block_index_out expected %0d actual %0d", $time,
                             e.idx, m_tdata);
                    errors++;
                end
                if (m_tuser !== e.stat) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.stat, m_tuser);
                    errors++;
                end
                case (e.stat)
                    STAT_OK:         n_ok++;
                    STAT_NO_SPACE:   n_nospace++;
                    STAT_BAD_SIZE:   n_bad++;
                    default:         n_misal++;
                endcase
            end
        end
    end

    initial begin
        int r;
        for (int l = 0; l <= LG; l++) fl_cnt[l] = 0;
        fl_store[lvl_base(LG)] = 0;
        fl_cnt[LG] = 1;

        // directed
        issue(CMD_ALLOC, HEAP, 0);
        issue(CMD_ALLOC, 1, 0);
        free_live(0);
        issue(CMD_FREE, HEAP, 0);
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_ALLOC, 2047, 1023);
        issue(CMD_ALLOC, HEAP + 1, 0);
        issue(CMD_FREE, 2, 3);
        issue(CMD_FREE, 0, 0);
        issue(CMD_FREE, 1, 1023);
        issue(CMD_FREE, HEAP, 512);
        issue(CMD_ALLOC, 1, 0);
        issue(CMD_ALLOC, 1, 0);
        issue(CMD_ALLOC, 3, 0);
        issue(CMD_ALLOC, 512, 0);
        issue(CMD_ALLOC, 512, 0);
        while (live.size() > 0) free_live(0);
        issue(CMD_ALLOC, HEAP, 0);
        issue(CMD_ALLOC, 1024, 0);
        while (live.size() > 0) free_live(0);

        for (int k = 0; k < N_RAND; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                issue(cmd_t'($urandom_range(0, 1)),
                      ($urandom_range(0, 1) ? 0 : $urandom_range(HEAP + 1, 2047)),
                      $urandom_range(0, HEAP - 1));
            end else if (r < 9) begin
                issue(CMD_FREE, rand_size(), $urandom_range(0, HEAP - 1));
            end else if (r < 11 && freed.size() > 0) begin
                issue(CMD_FREE, freed[0].n, freed[0].idx);
            end else if (r < 55 && live.size() < 32 || live.size() == 0) begin
                issue(CMD_ALLOC, rand_size(), $urandom_range(0, HEAP - 1));
            end else begin
                free_live($urandom_range(0, live.size() - 1));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (req_q.size() == 0 && !s_tvalid);
        wait (resp_q.size() == 0);
        repeat (60) @(posedge aclk);
        $display("Covered %0d results: %0d ok, %0d no space, %0d bad size, %0d misaligned.",
                 n_resp, n_ok, n_nospace, n_bad, n_misal);
        if (errors == 0 && resp_q.size() == 0) begin
            $display("[buddy_block_allocator_core] OK");
        end else begin
            $display("[buddy_block_allocator_core] ERROR");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, resp_q.size());
        $display("[buddy_block_allocator_core] ERROR");
        $finish;
    end

endmodule
